### hdl/tnpt_pkg.sv
package tnpt_pkg;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // request codes
   localparam logic [1:0] REQ_LOAD     = 2'd0;
   localparam logic [1:0] REQ_POS      = 2'd1;
   localparam logic [1:0] REQ_REL_TIME = 2'd2;
   localparam logic [1:0] REQ_ABS_TIME = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // last drain step: lets the memory read and the two registered stages of the distance pipe finish
   localparam logic [1:0] DRAIN_LAST = 2'd2;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   // one stored trajectory point
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] t;
   } point_type;

   // scan control from the sequencer to the search units
   typedef struct packed {
      logic start;
      logic beat;
   } scan_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

endpackage

### hdl/trajectory_nearest_point_table.sv
// a load, or a query on an empty table, goes from the finish state into the output register
// position query over n stored points: scans every stored point, one point memory read per cycle
// time query: the scan stops early once the first point at or above t is found, else at the last point
// a new word is taken once the previous result has moved into the output register
// reset (synchronous, active high) empties the table and clears the header time; no clearing pass
module trajectory_nearest_point_table #(
   parameter int DEPTH = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic               req_start_new,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [62:0] req_time_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [8:0]         rsp_match_index,
   output logic signed [31:0] rsp_match_x,
   output logic signed [31:0] rsp_match_y,
   output logic signed [31:0] rsp_match_time,
   output logic [9:0]         rsp_point_count,
   input  logic               csr_wr_en,
   input  logic [61:0]        csr_wr_data
);
   import tnpt_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // sequencer and table state
   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [61:0]        header_ff;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [1:0]         drain_ff, drain_in;

   // request held for the scan
   logic [1:0]         kind_ff;
   logic               use_hold_ff;
   logic [1:0]         hold_status_ff;
   logic [AW-1:0]      hold_idx_ff;
   point_type          hold_pt_ff;
   logic signed [31:0] qx_ff, qy_ff;
   logic signed [63:0] qt_ff, qt_in;

   // memory read beat, aligned with read data
   logic               beat_valid_ff;
   logic [AW-1:0]      beat_idx_ff;

   // output register, count held with the word
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [AW-1:0]      rsp_idx_ff;
   point_type          rsp_pt_ff;
   logic [CW-1:0]      rsp_count_ff;

   logic               accept, is_load, load_ok, mem_wr, rd_en, rsp_load, last, time_stop;
   logic [AW-1:0]      load_idx;
   logic signed [31:0] load_t, abs_t;
   logic signed [63:0] req_t64, rel_time;
   point_type          load_pt, rd_data, pos_pt, time_pt, res_pt;
   logic [AW-1:0]      pos_idx, time_idx, res_idx;
   logic [1:0]         res_status;
   logic               time_found;
   scan_ctl_type       ctl;
   logic [AW+8:0]      idx_wide;
   logic [CW+9:0]      count_wide;

   // request decode
   always_comb begin
      accept   = req_valid && req_ready;
      is_load  = (req_type == REQ_LOAD);
      // start_new empties the table first, so it never drops
      load_ok  = req_start_new || (count_ff != CW'(DEPTH));
      load_idx = req_start_new ? '0 : count_ff[AW-1:0];
      req_t64  = {req_time_us[62], req_time_us};
      load_t   = sat32(req_t64);
      load_pt  = '{x: req_pos_x, y: req_pos_y, t: load_t};
      // absolute time relative to the header, saturated to 32 bits
      rel_time = req_t64 - $signed({2'b00, header_ff});
      abs_t    = sat32(rel_time);
      qt_in    = (req_type == REQ_ABS_TIME) ? {{32{abs_t[31]}}, abs_t} : req_t64;
      mem_wr   = accept && is_load && load_ok;
      last     = (CW'(addr_ff) + CW'(1)) == count_ff;
      // the time unit stops the scan early once it has its hit
      time_stop = time_found && (kind_ff != REQ_POS);
      ctl.start = accept && !is_load;
      ctl.beat  = beat_valid_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (accept && is_load && load_ok) begin
         count_in = CW'(load_idx) + CW'(1);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      drain_in  = drain_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (is_load || count_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
                  addr_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            if (last || time_stop) begin
               state_in = ST_DRAIN;
               drain_in = '0;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            // let the distance pipe settle on its last point
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_FINISH;
            end else begin
               drain_in = drain_ff + 2'd1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         header_ff     <= '0;
         beat_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         beat_valid_ff <= rd_en;
         if (csr_wr_en) begin
            header_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      drain_ff    <= drain_in;
      beat_idx_ff <= addr_ff;
      if (accept) begin
         kind_ff     <= req_type;
         use_hold_ff <= is_load || (count_ff == '0);
         qx_ff       <= req_pos_x;
         qy_ff       <= req_pos_y;
         qt_ff       <= qt_in;
         if (is_load) begin
            hold_status_ff <= load_ok ? STATUS_OK : STATUS_FULL;
            hold_idx_ff    <= load_ok ? load_idx : '0;
            hold_pt_ff     <= load_ok ? load_pt : '0;
         end else begin
            hold_status_ff <= STATUS_EMPTY;
            hold_idx_ff    <= '0;
            hold_pt_ff     <= '0;
         end
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status;
         rsp_idx_ff    <= res_idx;
         rsp_pt_ff     <= res_pt;
         // count after this word, kept steady while the word waits
         rsp_count_ff  <= count_ff;
      end
   end

   // result selection
   always_comb begin
      if (use_hold_ff) begin
         res_status = hold_status_ff;
         res_idx    = hold_idx_ff;
         res_pt     = hold_pt_ff;
      end else if (kind_ff == REQ_POS) begin
         res_status = STATUS_OK;
         res_idx    = pos_idx;
         res_pt     = pos_pt;
      end else begin
         res_status = STATUS_OK;
         res_idx    = time_idx;
         res_pt     = time_pt;
      end
   end

   tnpt_point_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (load_idx),
      .wr_data (load_pt),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   tnpt_pos_unit #(.DEPTH(DEPTH)) u_pos (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .qx         (qx_ff),
      .qy         (qy_ff),
      .beat_idx   (beat_idx_ff),
      .beat_data  (rd_data),
      .best_idx   (pos_idx),
      .best_point (pos_pt)
   );

   tnpt_time_unit #(.DEPTH(DEPTH)) u_time (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .qt        (qt_ff),
      .beat_idx  (beat_idx_ff),
      .beat_data (rd_data),
      .found     (time_found),
      .sel_idx   (time_idx),
      .sel_point (time_pt)
   );

   // index and count wrap to the port widths
   assign idx_wide        = {9'd0, rsp_idx_ff};
   assign count_wide      = {10'd0, rsp_count_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = idx_wide[8:0];
   assign rsp_match_x     = rsp_pt_ff.x;
   assign rsp_match_y     = rsp_pt_ff.y;
   assign rsp_match_time  = rsp_pt_ff.t;
   assign rsp_point_count = count_wide[9:0];

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("point count above table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (CW'(addr_ff) < count_ff))
      else $error("scan read beyond stored points");

   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      (accept && is_load && req_start_new) |=> (count_ff == CW'(1)))
      else $error("restart load did not leave one point");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_EMPTY) |-> (rsp_count_ff == '0))
      else $error("empty status with points held");
`endif

endmodule

### hdl/tnpt_point_mem.sv
module tnpt_point_mem #(
   parameter int DEPTH = 512
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  tnpt_pkg::point_type          wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output tnpt_pkg::point_type          rd_data
);
   import tnpt_pkg::*;

   // contents undefined until written
   point_type mem_ff [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tnpt_pos_unit.sv
module tnpt_pos_unit #(
   parameter int DEPTH = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tnpt_pkg::scan_ctl_type       ctl,
   input  logic signed [31:0]           qx,
   input  logic signed [31:0]           qy,
   input  logic [$clog2(DEPTH)-1:0]     beat_idx,
   input  tnpt_pkg::point_type          beat_data,
   output logic [$clog2(DEPTH)-1:0]     best_idx,
   output tnpt_pkg::point_type          best_point
);
   import tnpt_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic signed [32:0] dx, dy;
   logic [31:0]        ax_in, ay_in;
   logic [64:0]        sq_dist;

   // stage 1: absolute differences
   logic               s1_valid_ff;
   logic [AW-1:0]      s1_idx_ff;
   point_type          s1_pt_ff;
   logic [31:0]        s1_ax_ff, s1_ay_ff;

   // stage 2: squares
   logic               s2_valid_ff;
   logic [AW-1:0]      s2_idx_ff;
   point_type          s2_pt_ff;
   logic [63:0]        s2_sqx_ff, s2_sqy_ff;

   // running minimum
   logic               best_valid_ff;
   logic [64:0]        best_dist_ff;
   logic [AW-1:0]      best_idx_ff;
   point_type          best_pt_ff;

   always_comb begin
      dx = {beat_data.x[31], beat_data.x} - {qx[31], qx};
      dy = {beat_data.y[31], beat_data.y} - {qy[31], qy};
      ax_in = dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
      ay_in = dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];
      sq_dist = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.beat;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= beat_idx;
      s1_pt_ff  <= beat_data;
      s1_ax_ff  <= ax_in;
      s1_ay_ff  <= ay_in;
      s2_idx_ff <= s1_idx_ff;
      s2_pt_ff  <= s1_pt_ff;
      s2_sqx_ff <= s1_ax_ff * s1_ax_ff;
      s2_sqy_ff <= s1_ay_ff * s1_ay_ff;
      // strict less-than keeps the first minimum
      if (s2_valid_ff && (!best_valid_ff || sq_dist < best_dist_ff)) begin
         best_dist_ff <= sq_dist;
         best_idx_ff  <= s2_idx_ff;
         best_pt_ff   <= s2_pt_ff;
      end
   end

   assign best_idx   = best_idx_ff;
   assign best_point = best_pt_ff;

endmodule

### hdl/tnpt_time_unit.sv
module tnpt_time_unit #(
   parameter int DEPTH = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tnpt_pkg::scan_ctl_type       ctl,
   input  logic signed [63:0]           qt,
   input  logic [$clog2(DEPTH)-1:0]     beat_idx,
   input  tnpt_pkg::point_type          beat_data,
   output logic                         found,
   output logic [$clog2(DEPTH)-1:0]     sel_idx,
   output tnpt_pkg::point_type          sel_point
);
   import tnpt_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic signed [63:0] cur_t64;
   logic signed [64:0] cur_t65, prev_t65, qt65;
   logic               at_or_above;
   logic               pick_hit;

   logic               found_ff;
   logic               hit_first_ff;
   logic [AW-1:0]      hit_idx_ff, prev_idx_ff;
   point_type          hit_pt_ff, prev_pt_ff;
   logic signed [64:0] d_hi_ff, d_lo_ff;

   always_comb begin
      cur_t64     = {{32{beat_data.t[31]}}, beat_data.t};
      cur_t65     = {{33{beat_data.t[31]}}, beat_data.t};
      prev_t65    = {{33{prev_pt_ff.t[31]}}, prev_pt_ff.t};
      qt65        = {qt[63], qt};
      at_or_above = cur_t64 >= qt;
      // neighbour tie goes to the earlier point
      pick_hit    = found_ff && (hit_first_ff || d_hi_ff < d_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         found_ff <= 1'b0;
      end else if (ctl.beat && at_or_above) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.beat && !found_ff) begin
         if (at_or_above) begin
            hit_idx_ff   <= beat_idx;
            hit_pt_ff    <= beat_data;
            hit_first_ff <= (beat_idx == '0);
            d_hi_ff      <= cur_t65 - qt65;
            d_lo_ff      <= qt65 - prev_t65;
         end else begin
            prev_idx_ff <= beat_idx;
            prev_pt_ff  <= beat_data;
         end
      end
   end

   assign found     = found_ff;
   assign sel_idx   = pick_hit ? hit_idx_ff : prev_idx_ff;
   assign sel_point = pick_hit ? hit_pt_ff : prev_pt_ff;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import tnpt_pkg::*;

   localparam int DEPTH = 512;
   // generous bound: every word a full scan, with the worst stalls on both sides, several times
   localparam int CYCLE_LIMIT = 2_000_000;
   // long receiver hold-off, so the block fills up and stalls its input
   localparam int HOLD_CYCLES = 400;
   localparam longint T63_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam longint T63_MIN = -64'sh4000_0000_0000_0000;
   localparam logic signed [31:0] X_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] X_MIN = 32'sh8000_0000;

   // one request word as it goes over the input channel
   typedef struct packed {
      logic [1:0]         kind;
      logic               start_new;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [62:0] t;
   } request_word_type;

   // one result word as it should come back
   typedef struct packed {
      logic [1:0]         status;
      logic [8:0]         index;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] t;
      logic [9:0]         count;
   } match_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = REQ_LOAD;
   logic               req_start_new = 1'b0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [62:0] req_time_us = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [8:0]         rsp_match_index;
   logic signed [31:0] rsp_match_x;
   logic signed [31:0] rsp_match_y;
   logic signed [31:0] rsp_match_time;
   logic [9:0]         rsp_point_count;
   logic               csr_wr_en = 1'b0;
   logic [61:0]        csr_wr_data = '0;

   // words waiting to be offered, and results still owed by the block
   request_word_type request_backlog[$];
   match_word_type   awaited_matches[$];

   // our own copy of the point table and header time
   logic signed [31:0] table_x [DEPTH];
   logic signed [31:0] table_y [DEPTH];
   logic signed [31:0] table_t [DEPTH];
   int unsigned        table_fill = 0;
   logic [61:0]        epoch_us = '0;

   // what the table will hold once the queued words are through, used to aim queries
   logic signed [31:0] plan_x[$];
   logic signed [31:0] plan_y[$];
   logic signed [31:0] plan_t[$];
   int unsigned        planned_items = 0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          stall_request = 0;
   int          stall_served = 0;
   int          hold_left = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   trajectory_nearest_point_table #(
      .DEPTH(DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_start_new  (req_start_new),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_time_us    (req_time_us),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_match_index(rsp_match_index),
      .rsp_match_x    (rsp_match_x),
      .rsp_match_y    (rsp_match_y),
      .rsp_match_time (rsp_match_time),
      .rsp_point_count(rsp_point_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   // saturate to signed 32 bits
   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > S32_MAX) return 32'sh7FFF_FFFF;
      if (v < S32_MIN) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // exact square of one coordinate gap, wide enough for the full range
   function automatic logic [65:0] sq_span(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
      longint      gap;
      logic [65:0] mag;
      gap = longint'(a) - longint'(b);
      if (gap < 0) gap = -gap;
      mag = 66'(gap);
      return mag * mag;
   endfunction

   // least squared distance over the table, first minimum wins
   function automatic int unsigned closest_by_place(input logic signed [31:0] qx,
                                                    input logic signed [31:0] qy);
      logic [65:0] best_d;
      logic [65:0] d;
      int unsigned best;
      best = 0;
      best_d = sq_span(table_x[0], qx) + sq_span(table_y[0], qy);
      for (int unsigned i = 1; i < table_fill; i++) begin
         d = sq_span(table_x[i], qx) + sq_span(table_y[i], qy);
         if (d < best_d) begin
            best_d = d;
            best = i;
         end
      end
      return best;
   endfunction

   // first point at or above t, clamped, then the nearer neighbour (tie to the earlier)
   function automatic int unsigned closest_by_instant(input longint t);
      int unsigned k;
      k = 0;
      while (k < table_fill && longint'(table_t[k]) < t) k++;
      if (k == 0) return 0;
      if (k >= table_fill) return table_fill - 1;
      if (longint'(table_t[k]) - t < t - longint'(table_t[k - 1])) return k;
      return k - 1;
   endfunction

   // work out the result of one accepted word and update our table copy
   task automatic forecast_match(input logic [1:0] kind, input logic start_new,
                                 input logic signed [31:0] x, input logic signed [31:0] y,
                                 input logic signed [62:0] t);
      match_word_type m;
      int unsigned    hit;
      m = '0;
      if (kind == REQ_LOAD) begin
         if (start_new) table_fill = 0;
         if (table_fill >= DEPTH) begin
            // table full: point dropped, count unchanged
            m.status = STATUS_FULL;
            m.count = table_fill[9:0];
         end else begin
            table_x[table_fill] = x;
            table_y[table_fill] = y;
            table_t[table_fill] = clamp32(longint'(t));
            m.status = STATUS_OK;
            m.index = table_fill[8:0];
            m.x = x;
            m.y = y;
            m.t = table_t[table_fill];
            table_fill++;
            m.count = table_fill[9:0];
         end
      end else if (table_fill == 0) begin
         m.status = STATUS_EMPTY;
      end else begin
         if (kind == REQ_POS) begin
            hit = closest_by_place(x, y);
         end else if (kind == REQ_REL_TIME) begin
            hit = closest_by_instant(longint'(t));
         end else begin
            hit = closest_by_instant(longint'(clamp32(longint'(t) - longint'(epoch_us))));
         end
         m.status = STATUS_OK;
         m.index = hit[8:0];
         m.x = table_x[hit];
         m.y = table_y[hit];
         m.t = table_t[hit];
         m.count = table_fill[9:0];
      end
      awaited_matches.insert(awaited_matches.size(), m);
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic longint any_time();
      logic signed [62:0] raw;
      raw = 63'({$urandom, $urandom});
      return longint'(raw);
   endfunction

   function automatic longint fit63(input longint v);
      if (v > T63_MAX) return T63_MAX;
      if (v < T63_MIN) return T63_MIN;
      return v;
   endfunction

   task automatic queue_word(input logic [1:0] kind, input logic start_new,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input longint t);
      request_word_type w;
      w.kind = kind;
      w.start_new = start_new;
      w.x = x;
      w.y = y;
      w.t = t[62:0];
      request_backlog.insert(request_backlog.size(), w);
      planned_items++;
      if (kind == REQ_LOAD) begin
         if (start_new) begin
            plan_x.delete();
            plan_y.delete();
            plan_t.delete();
         end
         if (plan_t.size() < DEPTH) begin
            plan_x.insert(plan_x.size(), x);
            plan_y.insert(plan_y.size(), y);
            plan_t.insert(plan_t.size(), clamp32(fit63(t)));
         end
      end
   endtask

   // a position near, on or between stored points, near the origin, or anywhere at all
   task automatic pick_place(output logic signed [31:0] x, output logic signed [31:0] y);
      int unsigned n;
      int unsigned i;
      int unsigned j;
      n = plan_x.size();
      i = (n == 0) ? 0 : $urandom_range(0, n - 1);
      j = (n == 0) ? 0 : $urandom_range(0, n - 1);
      case ((n == 0) ? 3 : $urandom_range(0, 6))
         0, 1: begin
            x = plan_x[i];
            y = plan_y[i];
         end
         2: begin
            x = plan_x[i] + (int'($urandom_range(0, 6)) - 3);
            y = plan_y[i] + (int'($urandom_range(0, 6)) - 3);
         end
         4: begin
            x = $urandom;
            y = $urandom;
         end
         5: begin
            // halfway between two points gives equal distances
            x = 32'((longint'(plan_x[i]) + longint'(plan_x[j])) >>> 1);
            y = 32'((longint'(plan_y[i]) + longint'(plan_y[j])) >>> 1);
         end
         default: begin
            x = int'($urandom_range(0, 10000)) - 5000;
            y = int'($urandom_range(0, 10000)) - 5000;
         end
      endcase
   endtask

   // a relative time aimed at stored times, midpoints and both ends, or anywhere at all
   function automatic longint pick_instant();
      int unsigned n;
      int unsigned k;
      longint      mid;
      n = plan_t.size();
      if (n == 0) return any_time();
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 7))
         0, 1: return plan_t[k];
         2, 3, 4: begin
            if (n < 2) return plan_t[k];
            k = $urandom_range(1, n - 1);
            mid = (longint'(plan_t[k - 1]) + longint'(plan_t[k])) >>> 1;
            return mid + longint'($urandom_range(0, 2)) - 1;
         end
         5: return longint'(plan_t[0]) - longint'($urandom_range(0, 50));
         6: return longint'(plan_t[n - 1]) + longint'($urandom_range(0, 50));
         default: return any_time();
      endcase
   endfunction

   // one load, times mostly rising with repeats, sometimes backwards or out of range
   task automatic add_load(inout longint stamp, input logic start_new);
      logic signed [31:0] px;
      logic signed [31:0] py;
      longint             t;
      case ($urandom_range(0, 19))
         0: stamp = stamp - longint'($urandom_range(1, 500));
         1, 2, 3: ;
         default: stamp = stamp + longint'($urandom_range(1, 3000));
      endcase
      t = ($urandom_range(0, 24) == 0) ? any_time() : stamp;
      pick_place(px, py);
      queue_word(REQ_LOAD, start_new, px, py, t);
   endtask

   // a fresh trajectory followed by a mix of queries, extra loads and noise
   task automatic plan_trajectory(input int unsigned points, input int unsigned extras);
      longint             stamp;
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      case ($urandom_range(0, 5))
         0: stamp = S32_MAX - longint'($urandom_range(0, 20000));
         1: stamp = S32_MIN + longint'($urandom_range(0, 20000));
         default: stamp = longint'($urandom_range(0, 200000)) - 100000;
      endcase
      add_load(stamp, 1'b1);
      for (int unsigned k = 1; k < points; k++) begin
         add_load(stamp, 1'b0);
      end
      for (int unsigned k = 0; k < extras; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2: add_load(stamp, 1'b0);
            3: queue_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          $urandom, $urandom, any_time());
            4, 5, 6, 7, 8, 9: begin
               pick_place(qx, qy);
               queue_word(REQ_POS, 1'($urandom_range(0, 1)), qx, qy, any_time());
            end
            10, 11, 12, 13, 14: queue_word(REQ_REL_TIME, 1'($urandom_range(0, 1)),
                                           $urandom, $urandom, pick_instant());
            default: queue_word(REQ_ABS_TIME, 1'($urandom_range(0, 1)), $urandom, $urandom,
                                fit63(longint'(epoch_us) + pick_instant()));
         endcase
      end
   endtask

   // mostly short trajectories, now and then a longer one
   task automatic plan_items(input int unsigned count);
      int unsigned goal;
      goal = planned_items + count;
      while (planned_items < goal) begin
         plan_trajectory(($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                     : $urandom_range(1, 12),
                         $urandom_range(4, 30));
      end
   endtask

   // wait until every queued word is through and every result is in
   task automatic settle();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || awaited_matches.size() != 0);
   endtask

   task automatic write_epoch(input logic [61:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      epoch_us = value;
      @(negedge clock);
   endtask

   task automatic compare_field(input string label, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------- request driver

   // offers the next word once the previous one is taken; may idle between words
   always @(posedge clock) begin : word_driver
      request_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            forecast_match(req_type, req_start_new, req_pos_x, req_pos_y, req_time_us);
         end
         if (!req_valid || req_ready) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_word = request_backlog.pop_front();
               req_type <= next_word.kind;
               req_start_new <= next_word.start_new;
               req_pos_x <= next_word.x;
               req_pos_y <= next_word.y;
               req_time_us <= next_word.t;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor

   // checks each result word against the oldest one awaited; stalls at random
   always @(posedge clock) begin : result_monitor
      match_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_matches.size() == 0) begin
               $display("%0t: result word with none awaited, expected nothing actual index %0d",
                        $time, rsp_match_index);
               mismatch_count++;
            end else begin
               want = awaited_matches.pop_front();
               compare_field("status", want.status, rsp_status);
               compare_field("match_index", want.index, rsp_match_index);
               compare_field("match_x", want.x, rsp_match_x);
               compare_field("match_y", want.y, rsp_match_y);
               compare_field("match_time", want.t, rsp_match_time);
               compare_field("point_count", want.count, rsp_point_count);
            end
         end
         // long hold-off, counted here
         if (stall_served != stall_request) begin
            stall_served = stall_request;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence of phases

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles a little, receiver a lot
      send_idle_pct = 23;
      recv_idle_pct = 56;

      // queries on the empty table
      queue_word(REQ_POS, 1'b0, 0, 0, 0);
      queue_word(REQ_REL_TIME, 1'b1, 0, 0, 0);
      queue_word(REQ_ABS_TIME, 1'b0, X_MAX, X_MIN, T63_MAX);
      // loads: repeated times, repeated place, saturating and backwards times
      queue_word(REQ_LOAD, 1'b1, 0, 0, 100);
      queue_word(REQ_LOAD, 1'b0, 5, 5, 200);
      queue_word(REQ_LOAD, 1'b0, 0, 0, 200);
      queue_word(REQ_LOAD, 1'b0, -7, 7, 300);
      queue_word(REQ_LOAD, 1'b0, X_MAX, X_MAX, T63_MAX);
      queue_word(REQ_LOAD, 1'b0, X_MIN, X_MIN, T63_MIN);
      // by position: tie on the same place, exact hit, widest gaps
      queue_word(REQ_POS, 1'b0, 0, 0, 0);
      queue_word(REQ_POS, 1'b1, X_MIN, X_MIN, 0);
      queue_word(REQ_POS, 1'b0, X_MAX, X_MIN, T63_MAX);
      queue_word(REQ_POS, 1'b0, X_MIN, X_MAX, T63_MIN);
      queue_word(REQ_POS, 1'b0, 3, 3, 0);
      // by relative time: exact, ties halfway, clamped at both ends
      queue_word(REQ_REL_TIME, 1'b0, 0, 0, 200);
      queue_word(REQ_REL_TIME, 1'b0, 0, 0, 150);
      queue_word(REQ_REL_TIME, 1'b0, 0, 0, 250);
      queue_word(REQ_REL_TIME, 1'b0, 0, 0, T63_MIN);
      queue_word(REQ_REL_TIME, 1'b1, 0, 0, T63_MAX);
      // by absolute time with the header still at zero, both saturations
      queue_word(REQ_ABS_TIME, 1'b1, 0, 0, 250);
      queue_word(REQ_ABS_TIME, 1'b0, 0, 0, T63_MIN);
      queue_word(REQ_ABS_TIME, 1'b0, 0, 0, 64'sd3000000000);
      settle();

      // header at its top value
      write_epoch(62'h3FFF_FFFF_FFFF_FFFF);
      plan_items(220);
      settle();

      // roles swapped: sender idles a lot, receiver a little, plus one long hold-off
      send_idle_pct = 56;
      recv_idle_pct = 23;
      write_epoch(62'($urandom_range(0, 50_000_000)));
      plan_items(200);
      stall_request++;
      settle();

      // header back to zero; fill the table, overfill it, query it full
      write_epoch('0);
      plan_trajectory(DEPTH + 3, 8);
      plan_items(60);
      settle();

      // no idling at all, header anywhere in its range
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_epoch(62'({$urandom, $urandom}));
      plan_items(150);
      settle();

      // room for any stray word after the last one owed
      repeat (DEPTH + 16) @(negedge clock);
      if (mismatch_count == 0 && awaited_matches.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
hdl/tnpt_pkg.sv
hdl/tnpt_point_mem.sv
hdl/tnpt_pos_unit.sv
hdl/tnpt_time_unit.sv
hdl/trajectory_nearest_point_table.sv
tb/tb.sv
